// ===== sv/avm_pkg.sv =====
`default_nettype none
package avm_pkg;
    localparam int WORD_BITS_DEF = 16;
    localparam logic [15:0] HALT_PC = 16'hFFFF;
    localparam logic [15:0] SP_RESET = 16'hFFFF;
    localparam logic [7:0] SP_BIAS = 8'd127;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_STEP  = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        OP_LD = 4'h0, OP_ST = 4'h1, OP_LDI = 4'h2, OP_STI = 4'h3,
        OP_ADD = 4'h4, OP_SUB = 4'h5, OP_SHL = 4'h6, OP_SHR = 4'h7,
        OP_MUL = 4'h8, OP_DIV = 4'h9, OP_AND = 4'hA, OP_OR = 4'hB,
        OP_NOT = 4'hC, OP_IMM = 4'hD, OP_JMP = 4'hE, OP_SPA = 4'hF
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLR, ST_FETCH, ST_DECODE, ST_OPRD, ST_EXEC, ST_INDRD,
        ST_DIV, ST_IO0, ST_IO1, ST_WB0, ST_DREAD, ST_OUT
    } state_t;

    localparam logic [2:0] CND_NEG = 3'd1, CND_POS = 3'd2, CND_ZERO = 3'd3,
        CND_NZ = 3'd4, CND_LE = 3'd5, CND_NN = 3'd6;

    function automatic logic cond_holds(input logic [2:0] c, input logic [15:0] a);
        logic z;
        logic n;
        z = (a == 16'd0);
        n = a[15];
        case (c)
            CND_NEG:  cond_holds = n;
            CND_POS:  cond_holds = !(z || n);
            CND_ZERO: cond_holds = z;
            CND_NZ:   cond_holds = !z;
            CND_LE:   cond_holds = z || n;
            CND_NN:   cond_holds = !n;
            default:  cond_holds = 1'b1;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== sv/avm_div.sv =====
`default_nettype none
module avm_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [15:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [15:0]      quotient
);
    logic [15:0] q_reg, q_next;
    logic [15:0] r_reg, r_next;
    logic [15:0] d_reg, d_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] trial;

    // restoring division, one quotient bit a cycle
    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg, q_reg[15]} - {1'b0, d_reg};
        if (start) begin
            q_next = dividend;
            r_next = 16'd0;
            d_next = divisor;
            cnt_next = 5'd16;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[16]) begin
                r_next = trial[15:0];
                q_next = {q_reg[14:0], 1'b1};
            end else begin
                r_next = {r_reg[14:0], q_reg[15]};
                q_next = {q_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = busy_reg && (cnt_reg == 5'd1);
    assign quotient = trial[16] ? {q_reg[14:0], 1'b0} : {q_reg[14:0], 1'b1};
endmodule
`default_nettype wire

// ===== sv/accumulator_vm_core_top.sv =====
`default_nettype none
// Accumulator machine core with 64K-word program and data memories, each a
// single-port synchronous RAM. A step runs fetch, operand read, optional
// indirect read or write, then a read-modify of the I/O words at data
// addresses 0 and 1; a divide also waits on the one-bit-a-cycle divider.
// After reset a clearing pass zeroes the data memory, one word a cycle,
// before the first beat is accepted. One result beat per input beat; the
// next input is taken once the result beat has left the output register.
module accumulator_vm_core_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_req_type,
    input  wire logic [avm_pkg::WORD_BITS_DEF-1:0]  s_addr,
    input  wire logic [avm_pkg::WORD_BITS_DEF-1:0]  s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [avm_pkg::WORD_BITS_DEF-1:0]       m_acc,
    output logic [avm_pkg::WORD_BITS_DEF-1:0]       m_pc,
    output logic [avm_pkg::WORD_BITS_DEF-1:0]       m_sp,
    output logic [1:0]                              m_io_command,
    output logic [avm_pkg::WORD_BITS_DEF-1:0]       m_io_char,
    output logic [avm_pkg::WORD_BITS_DEF-1:0]       m_read_data,
    output logic                                    m_halted
);
    localparam int DEPTH = 1 << avm_pkg::WORD_BITS_DEF;

    logic [avm_pkg::WORD_BITS_DEF-1:0] prog_mem [DEPTH];
    logic [avm_pkg::WORD_BITS_DEF-1:0] data_mem [DEPTH];

    avm_pkg::state_t state_reg, state_next;
    logic [15:0] acc_reg, acc_next, pc_reg, pc_next, sp_reg, sp_next;
    logic [15:0] ins_reg, ins_next, opa_reg, opa_next, v_reg, v_next;
    logic [15:0] addr_reg, addr_next, data_reg, data_next;
    logic [1:0]  req_reg, req_next;
    logic [16:0] clr_reg, clr_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [15:0] mul_reg, mul_next;
    logic        mul_pend_reg, mul_pend_next;
    // output register
    logic        ov_reg, ov_next;
    logic [15:0] o_acc_reg, o_acc_next, o_pc_reg, o_pc_next, o_sp_reg, o_sp_next;
    logic [1:0]  o_cmd_reg, o_cmd_next;
    logic [15:0] o_chr_reg, o_chr_next, o_rd_reg, o_rd_next;

    // memory ports
    logic        pwe, dwe;
    logic [15:0] paddr, daddr, pwdata, dwdata;
    logic [15:0] prdata_reg, drdata_reg;

    logic        div_start, div_done;
    logic [15:0] div_q;
    logic [3:0]  op;
    logic [7:0]  off;
    logic [15:0] spn;

    avm_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(acc_reg), .divisor(v_next), .done(div_done), .quotient(div_q)
    );

    always_ff @(posedge aclk) begin
        if (pwe) prog_mem[paddr] <= pwdata;
        prdata_reg <= prog_mem[paddr];
    end

    always_ff @(posedge aclk) begin
        if (dwe) data_mem[daddr] <= dwdata;
        drdata_reg <= data_mem[daddr];
    end

    assign op  = ins_reg[15:12];
    assign off = ins_reg[7:0];
    assign spn = sp_reg + {8'd0, off} - {8'd0, avm_pkg::SP_BIAS};

    always_comb begin
        state_next = state_reg;
        acc_next = acc_reg; pc_next = pc_reg; sp_next = sp_reg;
        ins_next = ins_reg; opa_next = opa_reg; v_next = v_reg;
        addr_next = addr_reg; data_next = data_reg; req_next = req_reg;
        clr_next = clr_reg; cmd_next = cmd_reg;
        mul_next = mul_reg; mul_pend_next = 1'b0;
        ov_next = ov_reg;
        o_acc_next = o_acc_reg; o_pc_next = o_pc_reg; o_sp_next = o_sp_reg;
        o_cmd_next = o_cmd_reg; o_chr_next = o_chr_reg; o_rd_next = o_rd_reg;
        pwe = 1'b0; dwe = 1'b0;
        paddr = pc_reg; daddr = opa_reg; pwdata = data_reg; dwdata = acc_reg;
        div_start = 1'b0;
        s_ready = 1'b0;
        if (ov_reg && m_ready) ov_next = 1'b0;
        case (state_reg)
            avm_pkg::ST_CLR: begin
                dwe = 1'b1; daddr = clr_reg[15:0]; dwdata = 16'd0;
                clr_next = clr_reg + 17'd1;
                if (clr_reg[16] || clr_reg == 17'(DEPTH - 1))
                    state_next = avm_pkg::ST_IDLE;
            end
            avm_pkg::ST_IDLE: begin
                s_ready = !ov_reg;
                if (s_valid && !ov_reg) begin
                    req_next = s_req_type;
                    addr_next = s_addr;
                    data_next = s_data;
                    state_next = avm_pkg::ST_FETCH;
                end
            end
            avm_pkg::ST_FETCH: begin
                // do the simple requests here, or fetch the instruction
                o_cmd_next = 2'd0; o_chr_next = 16'd0; o_rd_next = 16'd0;
                case (req_reg)
                    avm_pkg::REQ_LOAD: begin
                        pwe = 1'b1; paddr = addr_reg;
                        state_next = avm_pkg::ST_OUT;
                    end
                    avm_pkg::REQ_WRITE: begin
                        dwe = 1'b1; daddr = addr_reg; dwdata = data_reg;
                        state_next = avm_pkg::ST_OUT;
                    end
                    avm_pkg::REQ_READ: begin
                        daddr = addr_reg;
                        state_next = avm_pkg::ST_DREAD;
                    end
                    default: begin
                        paddr = pc_reg;
                        state_next = (pc_reg == avm_pkg::HALT_PC) ?
                            avm_pkg::ST_OUT : avm_pkg::ST_DECODE;
                    end
                endcase
            end
            avm_pkg::ST_DREAD: begin
                o_rd_next = drdata_reg;
                state_next = avm_pkg::ST_OUT;
            end
            avm_pkg::ST_DECODE: begin
                ins_next = prdata_reg;
                opa_next = sp_reg - {8'd0, prdata_reg[7:0]};
                state_next = avm_pkg::ST_OPRD;
            end
            avm_pkg::ST_OPRD: begin
                daddr = opa_reg;
                state_next = avm_pkg::ST_EXEC;
            end
            avm_pkg::ST_EXEC: begin
                v_next = drdata_reg;
                state_next = avm_pkg::ST_IO0;
                if (avm_pkg::cond_holds(ins_reg[10:8], acc_reg)) begin
                    case (op)
                        avm_pkg::OP_LD:  acc_next = drdata_reg;
                        avm_pkg::OP_ST:  begin dwe = 1'b1; daddr = opa_reg; end
                        avm_pkg::OP_LDI: begin
                            daddr = drdata_reg; state_next = avm_pkg::ST_INDRD;
                        end
                        avm_pkg::OP_STI: begin dwe = 1'b1; daddr = drdata_reg; end
                        avm_pkg::OP_ADD: acc_next = acc_reg + drdata_reg;
                        avm_pkg::OP_SUB: acc_next = acc_reg - drdata_reg;
                        avm_pkg::OP_SHL: acc_next = (drdata_reg[15:4] != 12'd0) ?
                            16'd0 : acc_reg << drdata_reg[3:0];
                        avm_pkg::OP_SHR: acc_next = (drdata_reg[15:4] != 12'd0) ?
                            16'd0 : acc_reg >> drdata_reg[3:0];
                        avm_pkg::OP_MUL: begin
                            mul_next = 16'(acc_reg * drdata_reg);
                            mul_pend_next = 1'b1;
                        end
                        avm_pkg::OP_DIV: begin
                            if (drdata_reg == 16'd0) acc_next = 16'hFFFF;
                            else state_next = avm_pkg::ST_DIV;
                        end
                        avm_pkg::OP_AND: acc_next = acc_reg & drdata_reg;
                        avm_pkg::OP_OR:  acc_next = acc_reg | drdata_reg;
                        avm_pkg::OP_NOT: acc_next = ~drdata_reg;
                        avm_pkg::OP_IMM: acc_next = {acc_reg[7:0], off};
                        avm_pkg::OP_JMP: pc_next = drdata_reg;
                        default: begin sp_next = spn; acc_next = spn; end
                    endcase
                end
                if (state_next == avm_pkg::ST_DIV) div_start = 1'b1;
            end
            avm_pkg::ST_INDRD: begin
                // hold the indirect address so the word is still there next cycle
                daddr = v_reg;
                state_next = avm_pkg::ST_WB0;
            end
            avm_pkg::ST_WB0: begin
                acc_next = drdata_reg;
                state_next = avm_pkg::ST_IO0;
            end
            avm_pkg::ST_DIV: begin
                if (div_done) begin
                    acc_next = div_q;
                    state_next = avm_pkg::ST_IO0;
                end
            end
            avm_pkg::ST_IO0: begin
                if (mul_pend_reg) acc_next = mul_reg;
                pc_next = pc_reg + 16'd1;
                daddr = 16'd0;
                state_next = avm_pkg::ST_IO1;
            end
            avm_pkg::ST_IO1: begin
                // word 0 captured, now read word 1 and clear word 0 after
                cmd_next = drdata_reg;
                daddr = 16'd1;
                state_next = avm_pkg::ST_OUT;
                o_cmd_next = 2'd3;
            end
            avm_pkg::ST_OUT: begin
                if (o_cmd_reg == 2'd3) begin
                    o_chr_next = drdata_reg;
                    o_cmd_next = (cmd_reg == 16'd1) ? 2'd1 :
                                 (cmd_reg == 16'd2) ? 2'd2 : 2'd0;
                    dwe = 1'b1; daddr = 16'd0; dwdata = 16'd0;
                end
                o_acc_next = acc_reg; o_pc_next = pc_reg; o_sp_next = sp_reg;
                ov_next = 1'b1;
                state_next = avm_pkg::ST_IDLE;
            end
            default: state_next = avm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= avm_pkg::ST_CLR;
            clr_reg <= 17'd0;
            acc_reg <= 16'd0;
            pc_reg <= 16'd0;
            sp_reg <= avm_pkg::SP_RESET;
            ov_reg <= 1'b0;
            mul_pend_reg <= 1'b0;
            o_cmd_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            acc_reg <= acc_next;
            pc_reg <= pc_next;
            sp_reg <= sp_next;
            ov_reg <= ov_next;
            mul_pend_reg <= mul_pend_next;
            o_cmd_reg <= o_cmd_next;
        end
        ins_reg <= ins_next; opa_reg <= opa_next; v_reg <= v_next;
        addr_reg <= addr_next; data_reg <= data_next; req_reg <= req_next;
        cmd_reg <= cmd_next; mul_reg <= mul_next;
        o_acc_reg <= o_acc_next; o_pc_reg <= o_pc_next; o_sp_reg <= o_sp_next;
        o_chr_reg <= o_chr_next; o_rd_reg <= o_rd_next;
    end

    assign m_valid = ov_reg;
    assign m_acc = o_acc_reg;
    assign m_pc = o_pc_reg;
    assign m_sp = o_sp_reg;
    assign m_io_command = o_cmd_reg;
    assign m_io_char = o_chr_reg;
    assign m_read_data = o_rd_reg;
    assign m_halted = (o_pc_reg == avm_pkg::HALT_PC);
endmodule
`default_nettype wire

// ===== sv/avm_checker.sv =====
`default_nettype none
module avm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_pc,
    input wire logic [1:0]  m_io_command,
    input wire logic        m_halted
);
    // result beat held until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pc))
        else $error("result beat dropped");
    // no input taken while a result is waiting
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken over a pending result");
    // io command code range
    a_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_io_command != 2'd3)
        else $error("bad io command");
    // halted flag matches pc
    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_halted == (m_pc == 16'hFFFF))
        else $error("halted flag wrong");
    // an accepted input gets no result in the cycle after it
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result too early");
endmodule

bind accumulator_vm_core_top avm_checker u_avm_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_pc(m_pc),
    .m_io_command(m_io_command), .m_halted(m_halted)
);
`default_nettype wire

// ===== dv/tb_accumulator_vm_core_top.sv =====
`timescale 1ns / 100ps

module tb_accumulator_vm_core_top;
    localparam int N_RANDOM = 1200;
    localparam int CALM_TAIL = 150;

    typedef struct {
        avm_pkg::req_t req;
        logic [15:0]   addr;
        logic [15:0]   data;
    } beat_t;

    typedef struct {
        logic [15:0] acc;
        logic [15:0] pc;
        logic [15:0] sp;
        logic [1:0]  io_command;
        logic [15:0] io_char;
        logic [15:0] read_data;
        logic        halted;
    } arch_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [15:0] s_addr;
    logic [15:0] s_data;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_acc;
    logic [15:0] m_pc;
    logic [15:0] m_sp;
    logic [1:0]  m_io_command;
    logic [15:0] m_io_char;
    logic [15:0] m_read_data;
    logic        m_halted;

    // shadow machine state
    bit [15:0] core_acc;
    bit [15:0] core_pc;
    bit [15:0] core_sp;
    bit [15:0] prog_mem [0:65535];
    bit [15:0] data_mem [0:65535];
    bit        prog_loaded [0:65535];

    beat_t beat_q[$];
    arch_t arch_q[$];
    int    n_total;
    int    n_sent;
    int    n_errors;
    bit    s_fire;
    int    s_gap;
    int    m_gap;

    accumulator_vm_core_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_addr       (s_addr),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_acc        (m_acc),
        .m_pc         (m_pc),
        .m_sp         (m_sp),
        .m_io_command (m_io_command),
        .m_io_char    (m_io_char),
        .m_read_data  (m_read_data),
        .m_halted     (m_halted)
    );

    // clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic bit cond_true(input logic [2:0] c, input logic [15:0] a);
        bit z;
        bit n;
        z = (a == 16'd0);
        n = a[15];
        case (c)
            avm_pkg::CND_NEG:  return n;
            avm_pkg::CND_POS:  return !z && !n;
            avm_pkg::CND_ZERO: return z;
            avm_pkg::CND_NZ:   return !z;
            avm_pkg::CND_LE:   return z || n;
            avm_pkg::CND_NN:   return !n;
            default:           return 1'b1;
        endcase
    endfunction

    // one beat through the shadow machine, queues the beat and its outcome
    task automatic exec_beat(input avm_pkg::req_t rq, input logic [15:0] ad,
                             input logic [15:0] dt);
        arch_t        r;
        logic [15:0]  ins;
        avm_pkg::op_t op;
        logic [7:0]   off;
        logic [15:0]  opa;
        logic [15:0]  v;
        logic [15:0]  a;
        logic [15:0]  npc;
        logic [15:0]  nsp;
        logic [15:0]  cmd;
        r.io_command = 2'd0;
        r.io_char = 16'd0;
        r.read_data = 16'd0;
        case (rq)
            avm_pkg::REQ_LOAD: begin
                prog_mem[ad] = dt;
                prog_loaded[ad] = 1'b1;
            end
            avm_pkg::REQ_WRITE: data_mem[ad] = dt;
            avm_pkg::REQ_READ:  r.read_data = data_mem[ad];
            default: begin
                if (core_pc != avm_pkg::HALT_PC) begin
                    ins = prog_mem[core_pc];
                    op = avm_pkg::op_t'(ins[15:12]);
                    off = ins[7:0];
                    opa = core_sp - {8'd0, off};
                    v = data_mem[opa];
                    a = core_acc;
                    npc = core_pc;
                    nsp = core_sp;
                    if (cond_true(ins[10:8], core_acc)) begin
                        case (op)
                            avm_pkg::OP_LD:  a = v;
                            avm_pkg::OP_ST:  data_mem[opa] = a;
                            avm_pkg::OP_LDI: a = data_mem[v];
                            avm_pkg::OP_STI: data_mem[v] = a;
                            avm_pkg::OP_ADD: a = a + v;
                            avm_pkg::OP_SUB: a = a - v;
                            avm_pkg::OP_SHL: a = (v >= 16) ? 16'd0 : a << v[3:0];
                            avm_pkg::OP_SHR: a = (v >= 16) ? 16'd0 : a >> v[3:0];
                            avm_pkg::OP_MUL: a = a * v;
                            avm_pkg::OP_DIV: a = (v == 16'd0) ? 16'hFFFF : a / v;
                            avm_pkg::OP_AND: a = a & v;
                            avm_pkg::OP_OR:  a = a | v;
                            avm_pkg::OP_NOT: a = ~v;
                            avm_pkg::OP_IMM: a = {a[7:0], off};
                            avm_pkg::OP_JMP: npc = v;
                            default: begin
                                nsp = core_sp + {8'd0, off} - {8'd0, avm_pkg::SP_BIAS};
                                a = nsp;
                            end
                        endcase
                    end
                    core_acc = a;
                    core_sp = nsp;
                    core_pc = npc + 16'd1;
                    cmd = data_mem[0];
                    r.io_command = (cmd == 16'd1) ? 2'd1 : (cmd == 16'd2) ? 2'd2 : 2'd0;
                    r.io_char = data_mem[1];
                    data_mem[0] = 16'd0;
                end
            end
        endcase
        r.acc = core_acc;
        r.pc = core_pc;
        r.sp = core_sp;
        r.halted = (core_pc == avm_pkg::HALT_PC);
        beat_q.push_back('{rq, ad, dt});
        arch_q.push_back(r);
    endtask

    // place an instruction at the current pc and step it
    task automatic run_ins(input avm_pkg::op_t op, input logic [2:0] c, input logic [7:0] off);
        exec_beat(avm_pkg::REQ_LOAD, core_pc, {op, 1'b0, c, off});
        exec_beat(avm_pkg::REQ_STEP, 16'($urandom), 16'($urandom));
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'($urandom_range(1, 2));
            2: return 16'($urandom_range(0, 20));
            3: return 16'hFFFF;
            4: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_ins();
        logic [2:0]   c;
        logic [7:0]   off;
        avm_pkg::op_t op;
        op = avm_pkg::op_t'($urandom_range(0, 15));
        c = ($urandom_range(0, 1) == 0) ? 3'd7 : 3'($urandom_range(0, 7));
        off = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        if (op == avm_pkg::OP_SPA && $urandom_range(0, 1) == 0)
            off = 8'($urandom_range(120, 134));
        return {op, 1'($urandom_range(0, 1)), c, off};
    endfunction

    // stimulus and expected outcomes
    initial begin
        int n;
        int r;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = '0;
        s_addr = '0;
        s_data = '0;
        m_ready = 1'b0;
        core_acc = '0;
        core_pc = '0;
        core_sp = avm_pkg::SP_RESET;

        // directed: operand window below sp
        exec_beat(avm_pkg::REQ_READ, 16'd0, 16'hFFFF);
        exec_beat(avm_pkg::REQ_WRITE, 16'hFFFF, 16'hFFFF);
        exec_beat(avm_pkg::REQ_WRITE, 16'hFFFE, 16'd16);
        exec_beat(avm_pkg::REQ_WRITE, 16'hFFFD, 16'd3);
        exec_beat(avm_pkg::REQ_WRITE, 16'hFFFC, 16'd0);
        run_ins(avm_pkg::OP_LD, 3'd0, 8'd0);
        run_ins(avm_pkg::OP_ADD, avm_pkg::CND_NEG, 8'd2);
        run_ins(avm_pkg::OP_SHL, 3'd7, 8'd1);
        run_ins(avm_pkg::OP_LD, avm_pkg::CND_ZERO, 8'd2);
        run_ins(avm_pkg::OP_SHR, avm_pkg::CND_POS, 8'd3);
        run_ins(avm_pkg::OP_DIV, avm_pkg::CND_NZ, 8'd3);
        run_ins(avm_pkg::OP_MUL, avm_pkg::CND_LE, 8'd2);
        run_ins(avm_pkg::OP_SUB, avm_pkg::CND_NN, 8'd0);
        run_ins(avm_pkg::OP_AND, avm_pkg::CND_ZERO, 8'd0);
        run_ins(avm_pkg::OP_OR, 3'd7, 8'd1);
        run_ins(avm_pkg::OP_NOT, 3'd7, 8'd3);
        run_ins(avm_pkg::OP_IMM, 3'd7, 8'hFF);
        run_ins(avm_pkg::OP_ST, 3'd7, 8'd5);
        run_ins(avm_pkg::OP_LDI, 3'd7, 8'd1);
        run_ins(avm_pkg::OP_STI, 3'd7, 8'd2);
        run_ins(avm_pkg::OP_JMP, 3'd7, 8'd2);
        run_ins(avm_pkg::OP_SPA, 3'd7, 8'd0);
        run_ins(avm_pkg::OP_SPA, 3'd7, 8'hFF);
        // io command words: output, input, other
        exec_beat(avm_pkg::REQ_WRITE, 16'd1, 16'h0041);
        exec_beat(avm_pkg::REQ_WRITE, 16'd0, 16'd1);
        run_ins(avm_pkg::OP_LD, 3'd7, 8'd0);
        exec_beat(avm_pkg::REQ_WRITE, 16'd0, 16'd2);
        run_ins(avm_pkg::OP_OR, 3'd7, 8'd0);
        exec_beat(avm_pkg::REQ_WRITE, 16'd0, 16'd7);
        run_ins(avm_pkg::OP_AND, 3'd7, 8'd0);

        // random programs with noise
        n = 0;
        while (n < N_RANDOM) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                // keep clear of the halt address until the end
                if (core_pc == 16'hFFFE) begin
                    exec_beat(avm_pkg::REQ_WRITE, core_sp, 16'h0010);
                    exec_beat(avm_pkg::REQ_LOAD, core_pc,
                        {avm_pkg::OP_JMP, 1'b0, 3'd7, 8'd0});
                    n += 2;
                end else if (!prog_loaded[core_pc] || $urandom_range(0, 3) == 0) begin
                    exec_beat(avm_pkg::REQ_LOAD, core_pc, rand_ins());
                    n++;
                end
                exec_beat(avm_pkg::REQ_STEP, 16'($urandom), 16'($urandom));
            end else if (r < 78) begin
                case ($urandom_range(0, 3))
                    0: exec_beat(avm_pkg::REQ_WRITE, 16'($urandom_range(0, 1)), rand_word());
                    1: exec_beat(avm_pkg::REQ_WRITE, 16'($urandom), 16'($urandom));
                    default: exec_beat(avm_pkg::REQ_WRITE,
                        core_sp - 16'($urandom_range(0, 15)), rand_word());
                endcase
            end else if (r < 90) begin
                if ($urandom_range(0, 1) == 0)
                    exec_beat(avm_pkg::REQ_READ, core_sp - 16'($urandom_range(0, 15)),
                        16'($urandom));
                else
                    exec_beat(avm_pkg::REQ_READ, 16'($urandom), 16'($urandom));
            end else begin
                exec_beat(avm_pkg::REQ_LOAD, 16'($urandom), 16'($urandom));
            end
            n++;
        end

        // jump to the halt address, then steps are ignored
        if (core_pc == 16'hFFFE)
            exec_beat(avm_pkg::REQ_LOAD, core_pc, {avm_pkg::OP_OR, 1'b0, 3'd7, 8'd0});
        if (core_pc == 16'hFFFE)
            exec_beat(avm_pkg::REQ_STEP, 16'd0, 16'd0);
        exec_beat(avm_pkg::REQ_WRITE, core_sp, 16'hFFFE);
        run_ins(avm_pkg::OP_JMP, 3'd7, 8'd0);
        exec_beat(avm_pkg::REQ_WRITE, 16'd0, 16'd1);
        exec_beat(avm_pkg::REQ_STEP, 16'hFFFF, 16'hFFFF);
        exec_beat(avm_pkg::REQ_LOAD, 16'h1234, 16'hABCD);
        exec_beat(avm_pkg::REQ_READ, 16'd0, 16'd0);
        exec_beat(avm_pkg::REQ_STEP, 16'd0, 16'd0);
        n_total = beat_q.size();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (beat_q.size() != 0 || arch_q.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // input side handshake record
    always @(posedge aclk) begin
        s_fire <= aresetn && s_valid && s_ready;
    end

    // input driver
    always @(negedge aclk) begin
        beat_t b;
        if (aresetn) begin
            if (!s_valid || s_fire) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_valid <= 1'b0;
                end else if (beat_q.size() != 0) begin
                    b = beat_q.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= b.req;
                    s_addr <= b.addr;
                    s_data <= b.data;
                    n_sent <= n_sent + 1;
                    if (n_sent < n_total - CALM_TAIL && $urandom_range(0, 5) == 0)
                        s_gap <= $urandom_range(1, 8);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side stalls
    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            m_ready <= 1'b0;
        end else if (aresetn && n_sent < n_total - CALM_TAIL && $urandom_range(0, 5) == 0) begin
            m_gap <= $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        arch_t w;
        if (aresetn && m_valid && m_ready) begin
            if (arch_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result beat: acc %h pc %h", m_acc, m_pc);
            end else begin
                w = arch_q.pop_front();
                if (m_acc !== w.acc || m_pc !== w.pc || m_sp !== w.sp
                        || m_io_command !== w.io_command || m_io_char !== w.io_char
                        || m_read_data !== w.read_data || m_halted !== w.halted) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"mismatch: exp acc %h pc %h sp %h cmd %0d chr %h rd %h ",
                            "hlt %0d / got acc %h pc %h sp %h cmd %0d chr %h rd %h hlt %0d"},
                            w.acc, w.pc, w.sp, w.io_command, w.io_char, w.read_data,
                            w.halted, m_acc, m_pc, m_sp, m_io_command, m_io_char,
                            m_read_data, m_halted);
                end
            end
        end
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== accumulator_vm_core_top.f =====
sv/avm_pkg.sv
sv/avm_div.sv
sv/accumulator_vm_core_top.sv
sv/avm_checker.sv
dv/tb_accumulator_vm_core_top.sv
